// ----- rtl/core/pbc_pkg.sv -----
// Shared types, constants and a helper function of the pty byte channel pair.
package pbc_pkg;

    localparam int RING_DEPTH = 8192;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int FILL_W     = 14;
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 32;

    localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(RING_DEPTH);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_READ    = 1'b1;
    localparam logic SIDE_SLAVE  = 1'b0;
    localparam logic SIDE_MASTER = 1'b1;

    localparam logic [1:0] REG_OUTPUT_POST     = 2'd0;
    localparam logic [1:0] REG_CRLF_MAP        = 2'd1;
    localparam logic [1:0] REG_MASTER_ATTACHED = 2'd2;
    localparam logic [1:0] REG_SLAVE_ATTACHED  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BLOCK  = 2'd1,
        ST_EOS    = 2'd2,
        ST_CLOSED = 2'd3
    } status_t;

    typedef struct packed {
        logic       action;
        logic       side;
        logic [7:0] data_in;
        logic       request_last;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [7:0]          read_data;
        logic [FILL_W-1:0]   master_rx_fill;
        logic [FILL_W-1:0]   slave_rx_fill;
        logic                request_done;
    } result_t;

    typedef struct packed {
        logic output_post;
        logic crlf_map;
        logic master_attached;
        logic slave_attached;
    } cfg_t;

    // Folds a position of up to twice the ring depth back into the ring.
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [CNT_W:0] pos);
        logic [CNT_W:0] folded;
        folded = (pos >= DEPTH_C) ? (pos - DEPTH_C) : pos;
        return PTR_W'(folded);
    endfunction

endpackage

// ----- rtl/core/pbc_ring_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module pbc_ring_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/pbc_cfg_regs.sv -----
// APB-style configuration registers of the pty byte channel pair.
module pbc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbc_pkg::CFG_AW-1:0]  paddr,
    input  logic [pbc_pkg::CFG_DW-1:0]  pwdata,
    output logic [pbc_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output pbc_pkg::cfg_t               cfg
);

    pbc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_post     <= 1'b1;
            cfg_reg.crlf_map        <= 1'b1;
            cfg_reg.master_attached <= 1'b1;
            cfg_reg.slave_attached  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pbc_pkg::REG_OUTPUT_POST:     cfg_reg.output_post     <= pwdata[0];
                pbc_pkg::REG_CRLF_MAP:        cfg_reg.crlf_map        <= pwdata[0];
                pbc_pkg::REG_MASTER_ATTACHED: cfg_reg.master_attached <= pwdata[0];
                pbc_pkg::REG_SLAVE_ATTACHED:  cfg_reg.slave_attached  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            pbc_pkg::REG_OUTPUT_POST:     prdata[0] = cfg_reg.output_post;
            pbc_pkg::REG_CRLF_MAP:        prdata[0] = cfg_reg.crlf_map;
            pbc_pkg::REG_MASTER_ATTACHED: prdata[0] = cfg_reg.master_attached;
            pbc_pkg::REG_SLAVE_ATTACHED:  prdata[0] = cfg_reg.slave_attached;
            default:                      prdata    = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/pbc_ring_ctrl.sv -----
// Sequencer that reads, modifies and writes the two byte rings, one beat at a time.
module pbc_ring_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  pbc_pkg::cfg_t    cfg,
    input  logic             start,
    input  pbc_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output pbc_pkg::result_t result
);

    localparam int PW = pbc_pkg::PTR_W;
    localparam int CW = pbc_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SECOND
    } state_t;

    state_t           state_reg, state_next;
    pbc_pkg::item_t   item_reg;
    logic [PW-1:0]    mb_head_reg, mb_head_next, sb_head_reg, sb_head_next;
    logic [CW-1:0]    mb_count_reg, mb_count_next, sb_count_reg, sb_count_next;
    pbc_pkg::result_t result_reg;
    logic             done_reg;

    logic             tgt_master;
    logic             peer;
    logic             expand;
    logic [PW-1:0]    head_sel;
    logic [CW-1:0]    count_sel;
    logic [PW-1:0]    tail;
    logic [PW-1:0]    head_inc;
    logic [CW-1:0]    count_new;
    logic             head_upd;
    logic             count_upd;
    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_wdata;
    logic [7:0]       mb_rdata, sb_rdata;
    logic             finish;
    pbc_pkg::status_t status_c;
    logic [7:0]       read_c;

    // Reads use the ring bound for the reader; writes use the one bound for the peer.
    assign tgt_master = (item_reg.action == pbc_pkg::ACT_READ)
                        ? (item_reg.side == pbc_pkg::SIDE_MASTER)
                        : (item_reg.side == pbc_pkg::SIDE_SLAVE);
    assign peer       = (item_reg.side == pbc_pkg::SIDE_MASTER)
                        ? cfg.slave_attached : cfg.master_attached;
    assign expand     = (item_reg.side == pbc_pkg::SIDE_SLAVE)
                        && (item_reg.data_in == pbc_pkg::CH_LF)
                        && cfg.output_post && cfg.crlf_map;
    assign head_sel   = tgt_master ? mb_head_reg : sb_head_reg;
    assign count_sel  = tgt_master ? mb_count_reg : sb_count_reg;
    assign tail       = pbc_pkg::ring_wrap((CW + 1)'(head_sel) + (CW + 1)'(count_sel));
    assign head_inc   = pbc_pkg::ring_wrap((CW + 1)'(head_sel) + (CW + 1)'(1));

    always_comb
    begin
        state_next = state_reg;
        head_upd   = 1'b0;
        count_upd  = 1'b0;
        count_new  = count_sel;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wdata  = item_reg.data_in;
        finish     = 1'b0;
        status_c   = pbc_pkg::ST_OK;
        read_c     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (item_reg.action == pbc_pkg::ACT_READ)
                begin
                    if (count_sel == '0)
                    begin
                        status_c   = peer ? pbc_pkg::ST_BLOCK : pbc_pkg::ST_EOS;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        head_upd   = 1'b1;
                        count_upd  = 1'b1;
                        count_new  = count_sel - CW'(1);
                        state_next = S_READ;
                    end
                end
                else if (!peer)
                begin
                    status_c   = pbc_pkg::ST_CLOSED;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (expand)
                begin
                    if ((CW + 1)'(count_sel) + (CW + 1)'(2) > pbc_pkg::DEPTH_C)
                    begin
                        status_c   = pbc_pkg::ST_BLOCK;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = pbc_pkg::CH_CR;
                        count_upd  = 1'b1;
                        count_new  = count_sel + CW'(1);
                        state_next = S_SECOND;
                    end
                end
                else if ((CW + 1)'(count_sel) >= pbc_pkg::DEPTH_C)
                begin
                    status_c   = pbc_pkg::ST_BLOCK;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_upd  = 1'b1;
                    count_new  = count_sel + CW'(1);
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                read_c     = tgt_master ? mb_rdata : sb_rdata;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_SECOND:
            begin
                // The carriage return is already in; now the line feed follows it.
                mem_we     = 1'b1;
                count_upd  = 1'b1;
                count_new  = count_sel + CW'(1);
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mb_head_next  = mb_head_reg;
        sb_head_next  = sb_head_reg;
        mb_count_next = mb_count_reg;
        sb_count_next = sb_count_reg;
        if (tgt_master)
        begin
            if (head_upd)  mb_head_next  = head_inc;
            if (count_upd) mb_count_next = count_new;
        end
        else
        begin
            if (head_upd)  sb_head_next  = head_inc;
            if (count_upd) sb_count_next = count_new;
        end
    end

    pbc_ring_ram #(
        .DEPTH (pbc_pkg::RING_DEPTH),
        .WIDTH (8),
        .AW    (PW)
    ) u_mb_ram (
        .clk   (clk),
        .we    (mem_we && tgt_master),
        .waddr (tail),
        .wdata (mem_wdata),
        .re    (mem_re && tgt_master),
        .raddr (head_sel),
        .rdata (mb_rdata)
    );

    pbc_ring_ram #(
        .DEPTH (pbc_pkg::RING_DEPTH),
        .WIDTH (8),
        .AW    (PW)
    ) u_sb_ram (
        .clk   (clk),
        .we    (mem_we && !tgt_master),
        .waddr (tail),
        .wdata (mem_wdata),
        .re    (mem_re && !tgt_master),
        .raddr (head_sel),
        .rdata (sb_rdata)
    );

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mb_head_reg  <= '0;
            sb_head_reg  <= '0;
            mb_count_reg <= '0;
            sb_count_reg <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mb_head_reg  <= mb_head_next;
            sb_head_reg  <= sb_head_next;
            mb_count_reg <= mb_count_next;
            sb_count_reg <= sb_count_next;
            done_reg     <= finish;
            if (finish)
            begin
                result_reg.status         <= status_c;
                result_reg.read_data      <= read_c;
                result_reg.master_rx_fill <= pbc_pkg::FILL_W'(mb_count_next);
                result_reg.slave_rx_fill  <= pbc_pkg::FILL_W'(sb_count_next);
                result_reg.request_done   <= item_reg.request_last;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/pty_byte_channel_pair.sv -----
// Top level of the pty byte channel pair: configuration registers and ring sequencer.
//
// The block joins a master and a slave endpoint through two byte rings of
// RING_DEPTH bytes each. A beat on the command channel is taken at a rising
// edge where start is high and busy is low; it carries one byte access
// (read or write) from one side. Master writes land in the slave-bound
// ring, slave writes in the master-bound ring, and a read takes the oldest
// byte of the ring bound for the reader. With output processing and newline
// mapping on, a slave line feed is stored as carriage return then line feed.
// Every accepted beat yields exactly one result beat, marked by done for a
// single cycle; the receiver cannot stall it.
// Rejected accesses and plain writes finish in the execute state; a read
// passes through a further state because the ring memory has a registered
// read port, and a mapped line feed does too (two writes through the single
// memory write port). busy drops in the cycle where done is high, so the
// next beat can be taken at the edge that takes the result.
// Reset empties both rings by clearing heads and counts and loads the
// registers with output_post=1, crlf_map=1, master_attached=1 and
// slave_attached=0; the ring memories themselves are not cleared.
module pty_byte_channel_pair (
    input  logic                        clk,
    input  logic                        rst_n,
    // Command channel
    input  logic                        start,
    output logic                        busy,
    input  pbc_pkg::item_t              item,
    // Result channel
    output logic                        done,
    output pbc_pkg::result_t            result,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbc_pkg::CFG_AW-1:0]  paddr,
    input  logic [pbc_pkg::CFG_DW-1:0]  pwdata,
    output logic [pbc_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    pbc_pkg::cfg_t cfg;

    // Register file; the user must write it only while the sequencer is idle, which the block itself does not enforce.
    pbc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Ring memories plus the read-modify-write sequencer around them.
    pbc_ring_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the pty byte channel pair.
`timescale 1ns / 100ps

module tb;

    // Ring numbering inside the scoreboard: the ring read by the master and
    // the ring read by the slave.
    localparam int RING_MASTER_RX = 0;
    localparam int RING_SLAVE_RX  = 1;

    // Keeps its own copy of both rings and of the registers, works out the
    // result beat of every accepted command beat, and checks result beats
    // against those expectations in order.
    class pty_ring_checker;
        pbc_pkg::cfg_t    cfg;
        logic [7:0]       ring_bytes [2][pbc_pkg::RING_DEPTH];
        int               ring_head [2];
        int               ring_fill [2];
        pbc_pkg::result_t expected_results [$];
        int               mismatch_count;
        int               result_index;

        function new();
            cfg = '{output_post: 1'b1, crlf_map: 1'b1,
                    master_attached: 1'b1, slave_attached: 1'b0};
            ring_head = '{0, 0};
            ring_fill = '{0, 0};
            mismatch_count = 0;
            result_index = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        function void push_byte(int r, logic [7:0] b);
            ring_bytes[r][(ring_head[r] + ring_fill[r]) % pbc_pkg::RING_DEPTH] = b;
            ring_fill[r]++;
        endfunction

        function void note_access(pbc_pkg::item_t it);
            pbc_pkg::result_t exp;
            logic             peer;
            logic             expand;
            int               r;
            int               need;
            exp = '0;
            exp.request_done = it.request_last;
            peer = (it.side == pbc_pkg::SIDE_MASTER) ? cfg.slave_attached
                                                      : cfg.master_attached;
            if (it.action == pbc_pkg::ACT_READ)
            begin
                r = (it.side == pbc_pkg::SIDE_MASTER) ? RING_MASTER_RX : RING_SLAVE_RX;
                if (ring_fill[r] == 0)
                begin
                    exp.status = peer ? pbc_pkg::ST_BLOCK : pbc_pkg::ST_EOS;
                end
                else
                begin
                    exp.read_data = ring_bytes[r][ring_head[r]];
                    ring_head[r] = (ring_head[r] + 1) % pbc_pkg::RING_DEPTH;
                    ring_fill[r]--;
                    exp.status = pbc_pkg::ST_OK;
                end
            end
            else
            begin
                r = (it.side == pbc_pkg::SIDE_MASTER) ? RING_SLAVE_RX : RING_MASTER_RX;
                if (!peer)
                begin
                    exp.status = pbc_pkg::ST_CLOSED;
                end
                else
                begin
                    expand = (it.side == pbc_pkg::SIDE_SLAVE) &&
                             (it.data_in == pbc_pkg::CH_LF) &&
                             cfg.output_post && cfg.crlf_map;
                    need = expand ? 2 : 1;
                    if (pbc_pkg::RING_DEPTH - ring_fill[r] < need)
                    begin
                        exp.status = pbc_pkg::ST_BLOCK;
                    end
                    else
                    begin
                        if (expand)
                        begin
                            push_byte(r, pbc_pkg::CH_CR);
                        end
                        push_byte(r, it.data_in);
                        exp.status = pbc_pkg::ST_OK;
                    end
                end
            end
            exp.master_rx_fill = pbc_pkg::FILL_W'(ring_fill[RING_MASTER_RX]);
            exp.slave_rx_fill  = pbc_pkg::FILL_W'(ring_fill[RING_SLAVE_RX]);
            expected_results.push_back(exp);
        endfunction

        task check_result(pbc_pkg::result_t got);
            pbc_pkg::result_t exp;
            result_index++;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result beat %0d arrived with nothing expected",
                                 result_index));
                return;
            end
            exp = expected_results.pop_front();
            if (got.status !== exp.status)
                report($sformatf("beat %0d status %0d, expected %0d",
                                 result_index, got.status, exp.status));
            if (got.read_data !== exp.read_data)
                report($sformatf("beat %0d read_data %h, expected %h",
                                 result_index, got.read_data, exp.read_data));
            if (got.master_rx_fill !== exp.master_rx_fill)
                report($sformatf("beat %0d master_rx_fill %0d, expected %0d",
                                 result_index, got.master_rx_fill, exp.master_rx_fill));
            if (got.slave_rx_fill !== exp.slave_rx_fill)
                report($sformatf("beat %0d slave_rx_fill %0d, expected %0d",
                                 result_index, got.slave_rx_fill, exp.slave_rx_fill));
            if (got.request_done !== exp.request_done)
                report($sformatf("beat %0d request_done %b, expected %b",
                                 result_index, got.request_done, exp.request_done));
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    pbc_pkg::item_t               item;
    logic                         done;
    pbc_pkg::result_t             result;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [pbc_pkg::CFG_AW-1:0]   paddr;
    logic [pbc_pkg::CFG_DW-1:0]   pwdata;
    logic [pbc_pkg::CFG_DW-1:0]   prdata;
    logic                         pready;

    pty_ring_checker sb = new();

    // When set, the command side inserts random gaps between beats.
    bit idle_on;

    always #4 clk = ~clk;

    pty_byte_channel_pair dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Result beats last one cycle and cannot be stalled, so every edge with
    // done high is a beat. The values read here are the ones from before
    // the edge, because the block updates its outputs in the NBA region.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            sb.check_result(result);
        end
    end

    function automatic pbc_pkg::item_t make_item(logic act, logic sd, logic [7:0] data,
                                                 logic last);
        pbc_pkg::item_t it;
        it.action       = act;
        it.side         = sd;
        it.data_in      = data;
        it.request_last = last;
        return it;
    endfunction

    // Writes are slightly more common than reads so the rings hold some
    // bytes most of the time; line feeds are common to hit the mapping.
    function automatic pbc_pkg::item_t random_item();
        pbc_pkg::item_t it;
        it.action       = ($urandom_range(0, 99) < 45) ? pbc_pkg::ACT_READ
                                                       : pbc_pkg::ACT_WRITE;
        it.side         = 1'($urandom_range(0, 1));
        it.data_in      = ($urandom_range(0, 3) == 0) ? pbc_pkg::CH_LF
                                                      : 8'($urandom_range(0, 255));
        it.request_last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Presents one command beat and returns at the edge that takes it. start
    // is left high afterward so back-to-back beats never lower and raise it
    // in the same time step; a gap or a drain is what lowers it.
    task automatic send_beat(input pbc_pkg::item_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_access(it);
    endtask

    // Stops sending and waits until every expected result beat has shown
    // up or max_cycles have passed, then lets a few more cycles pass so the sequencer is idle.
    task automatic drain_results(input int max_cycles);
        int waited;
        waited = 0;
        start <= 1'b0;
        while (sb.expected_results.size() != 0 && waited < max_cycles)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // One register write: setup cycle, then the access cycle that commits
    // at the edge where pready is seen high.
    task automatic write_reg(input logic [1:0] idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pbc_pkg::CFG_AW'({idx, 2'b00});
        // Upper bits are random; only the low bit is meant to be kept.
        pwdata  <= {31'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pbc_pkg::REG_OUTPUT_POST:     sb.cfg.output_post     = value;
            pbc_pkg::REG_CRLF_MAP:        sb.cfg.crlf_map        = value;
            pbc_pkg::REG_MASTER_ATTACHED: sb.cfg.master_attached = value;
            default:                      sb.cfg.slave_attached  = value;
        endcase
    endtask

    task automatic set_config(input pbc_pkg::cfg_t c);
        write_reg(pbc_pkg::REG_OUTPUT_POST, c.output_post);
        write_reg(pbc_pkg::REG_CRLF_MAP, c.crlf_map);
        write_reg(pbc_pkg::REG_MASTER_ATTACHED, c.master_attached);
        write_reg(pbc_pkg::REG_SLAVE_ATTACHED, c.slave_attached);
    endtask

    // A phase of random beats under one register setting. The first two
    // phases use the extremes, later ones mostly keep both sides attached
    // so that data actually moves.
    task automatic random_phase(input int phase, input int n_items, input bit with_gaps);
        pbc_pkg::cfg_t c;
        drain_results(200);
        if (phase == 0)
            c = '1;
        else if (phase == 1)
            c = '0;
        else
        begin
            c.output_post     = 1'($urandom_range(0, 1));
            c.crlf_map        = 1'($urandom_range(0, 1));
            c.master_attached = ($urandom_range(0, 3) != 0);
            c.slave_attached  = ($urandom_range(0, 3) != 0);
        end
        set_config(c);
        idle_on = with_gaps;
        for (int i = 0; i < n_items; i++)
        begin
            // Now and then the sender holds off until nothing is pending.
            if (i == n_items / 2 && phase % 3 == 2)
            begin
                drain_results(200);
            end
            send_beat(random_item());
        end
    endtask

    initial
    begin
        pbc_pkg::cfg_t c;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        idle_on = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset setting: master attached, slave not.
        // Empty reads give would block on the slave side and end of stream
        // on the master side; a master write finds its peer closed.
        send_beat(make_item(pbc_pkg::ACT_READ,  pbc_pkg::SIDE_SLAVE,  8'h00, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_READ,  pbc_pkg::SIDE_MASTER, 8'hFF, 1'b1));
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_MASTER, 8'h55, 1'b1));
        // Slave writes, the line feed expanding to carriage return first.
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_SLAVE, 8'h00, 1'b1));
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_SLAVE, pbc_pkg::CH_LF, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_SLAVE, 8'hFF, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_SLAVE, pbc_pkg::CH_CR, 1'b1));
        repeat (5)
            send_beat(make_item(pbc_pkg::ACT_READ, pbc_pkg::SIDE_MASTER, 8'hAA, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_READ, pbc_pkg::SIDE_MASTER, 8'h00, 1'b1));

        // Slave attached, mapping off: the line feed goes through alone.
        drain_results(200);
        c = '{output_post: 1'b1, crlf_map: 1'b0,
              master_attached: 1'b1, slave_attached: 1'b1};
        set_config(c);
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_SLAVE, pbc_pkg::CH_LF, 1'b1));
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_MASTER, 8'hAA, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_MASTER, pbc_pkg::CH_LF, 1'b1));
        repeat (3)
            send_beat(make_item(pbc_pkg::ACT_READ, pbc_pkg::SIDE_SLAVE, 8'h00, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_READ, pbc_pkg::SIDE_MASTER, 8'h00, 1'b1));
        send_beat(make_item(pbc_pkg::ACT_READ, pbc_pkg::SIDE_MASTER, 8'h00, 1'b0));

        // Master gone: slave writes are refused and an empty slave read is
        // end of stream, while the master side still works.
        drain_results(200);
        c = '{output_post: 1'b0, crlf_map: 1'b1,
              master_attached: 1'b0, slave_attached: 1'b1};
        set_config(c);
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_SLAVE, pbc_pkg::CH_LF, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_READ,  pbc_pkg::SIDE_SLAVE,  8'h00, 1'b1));
        send_beat(make_item(pbc_pkg::ACT_WRITE, pbc_pkg::SIDE_MASTER, 8'h01, 1'b0));
        send_beat(make_item(pbc_pkg::ACT_READ,  pbc_pkg::SIDE_SLAVE,  8'h00, 1'b1));

        for (int p = 0; p < 6; p++)
        begin
            random_phase(p, 150, p != 3);
        end

        for (int p = 6; p < 12; p++)
        begin
            random_phase(p, 150, p != 8 && p != 11);
        end

        // All stimulus is in; collect the tail of the results.
        drain_results(1000);
        repeat (8) @(posedge clk);
        if (sb.expected_results.size() != 0)
        begin
            sb.report($sformatf("%0d result beats never arrived",
                                sb.expected_results.size()));
        end
        if (sb.mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest legal run.
    initial
    begin
        #30000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pbc_pkg.sv
rtl/core/pbc_ring_ram.sv
rtl/core/pbc_cfg_regs.sv
rtl/core/pbc_ring_ctrl.sv
rtl/core/pty_byte_channel_pair.sv
sim/tb.sv
